/* rtl/gradient_noise_3d_unit_macros.svh */
// Assertion macros for the gradient noise unit.
`ifndef GRADIENT_NOISE_3D_UNIT_MACROS_SVH
`define GRADIENT_NOISE_3D_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define GN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GN_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GN_ASSERT(label, clk, rst_n, prop, msg)
`define GN_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* rtl/gn3d_pkg.sv */
`timescale 1ns / 1ps
package gn3d_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned OutW   = 18;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned PermDepth = 256;

  typedef enum logic {
    ACT_EVAL  = 1'b0,
    ACT_WRITE = 1'b1
  } action_e;

  typedef struct packed {
    logic               action;
    logic [IdxW-1:0]    table_index;
    logic [IdxW-1:0]    table_value;
    logic [CoordW-1:0]  coord_x;
    logic [CoordW-1:0]  coord_y;
    logic [CoordW-1:0]  coord_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] noise_value;
  } out_item_t;

  // Pipeline flow control shared between the datapath and the output stage.
  typedef struct packed {
    logic adv;
    logic out_valid;
  } pipe_ctrl_t;
endpackage

/* rtl/gn3d_if.sv */
`timescale 1ns / 1ps
interface gn3d_in_if;
  import gn3d_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gn3d_out_if;
  import gn3d_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/gn3d_ram.sv */
`timescale 1ns / 1ps
module gn3d_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end
  assign rdata_o = rdata_q;
endmodule

/* rtl/gn3d_hash.sv */
`timescale 1ns / 1ps
// Corner hash: three levels of table lookups, fourteen table copies.
// A write reaches each level one advance after the level before it, in step
// with the reads, so lookups always see the table as of their own transaction.
// Reads are registered, stalls gate enables.
module gn3d_hash (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] x_i,
  input  logic [7:0] y_i,
  input  logic [7:0] z_i,
  output logic [7:0] h_o [8]
);
  // write delayed for levels 2 and 3
  logic       we1_q, we2_q;
  logic [7:0] wa1_q, wa2_q, wd1_q, wd2_q;
  logic       we1_en, we2_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      we1_q <= 1'b0;
      we2_q <= 1'b0;
    end else if (adv_i) begin
      we1_q <= we_i;
      we2_q <= we1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wa1_q <= waddr_i;
      wd1_q <= wdata_i;
      wa2_q <= wa1_q;
      wd2_q <= wd1_q;
    end
  end
  assign we1_en = we1_q && adv_i;
  assign we2_en = we2_q && adv_i;

  // level 1: p[X], p[X+1] (result valid one advance later)
  logic [7:0] l1_r [2];
  logic [7:0] l1_a [2];
  logic [7:0] y_q, z_q, z2_q;
  assign l1_a[0] = x_i;
  assign l1_a[1] = x_i + 8'd1;

  for (genvar g = 0; g < 2; g++) begin : g_l1
    gn3d_ram #(.Width(8), .Depth(256)) u_ram (
      .clk_i, .we_i, .waddr_i, .wdata_i,
      .re_i(adv_i), .raddr_i(l1_a[g]), .rdata_o(l1_r[g]));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      y_q  <= y_i;
      z_q  <= z_i;
      z2_q <= z_q;
    end
  end

  // level 2: A, A+1, B, B+1
  logic [7:0] l2_a [4];
  logic [7:0] l2_r [4];
  logic [7:0] a_s, b_s;
  assign a_s = l1_r[0] + y_q;
  assign b_s = l1_r[1] + y_q;
  assign l2_a[0] = a_s;
  assign l2_a[1] = a_s + 8'd1;
  assign l2_a[2] = b_s;
  assign l2_a[3] = b_s + 8'd1;

  for (genvar g = 0; g < 4; g++) begin : g_l2
    gn3d_ram #(.Width(8), .Depth(256)) u_ram (
      .clk_i, .we_i(we1_en), .waddr_i(wa1_q), .wdata_i(wd1_q),
      .re_i(adv_i), .raddr_i(l2_a[g]), .rdata_o(l2_r[g]));
  end

  // level 3: corner order AA, BA, AB, BB, AA+1, BA+1, AB+1, BB+1
  logic [7:0] aa, ab, ba, bb;
  logic [7:0] l3_a [8];
  assign aa = l2_r[0] + z2_q;
  assign ab = l2_r[1] + z2_q;
  assign ba = l2_r[2] + z2_q;
  assign bb = l2_r[3] + z2_q;
  assign l3_a[0] = aa;
  assign l3_a[1] = ba;
  assign l3_a[2] = ab;
  assign l3_a[3] = bb;
  assign l3_a[4] = aa + 8'd1;
  assign l3_a[5] = ba + 8'd1;
  assign l3_a[6] = ab + 8'd1;
  assign l3_a[7] = bb + 8'd1;

  for (genvar g = 0; g < 8; g++) begin : g_l3
    gn3d_ram #(.Width(8), .Depth(256)) u_ram (
      .clk_i, .we_i(we2_en), .waddr_i(wa2_q), .wdata_i(wd2_q),
      .re_i(adv_i), .raddr_i(l3_a[g]), .rdata_o(h_o[g]));
  end
endmodule

/* rtl/gn3d_blend.sv */
`timescale 1ns / 1ps
// One registered rounding multiply: a + round(t*(b-a) / 2^Fb).
module gn3d_blend #(
  parameter int unsigned Fb = 16,
  parameter int unsigned Vw = 20
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic signed [Fb+1:0] t_i,
  input  logic signed [Vw-1:0] a_i,
  input  logic signed [Vw-1:0] b_i,
  output logic signed [Vw-1:0] r_o
);
  localparam int unsigned Pw = Fb + Vw + 3;
  logic signed [Vw:0]   diff;
  logic signed [Pw-1:0] prod, rnd;
  logic signed [Vw-1:0] r_q;
  assign diff = Vw'(b_i) - Vw'(a_i) + (Vw+1)'(0);
  assign prod = Pw'(t_i) * Pw'(diff);
  assign rnd  = prod + (Pw'(1) <<< (Fb - 1));
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      r_q <= a_i + Vw'(rnd >>> Fb);
    end
  end
  assign r_o = r_q;
endmodule

/* rtl/gradient_noise_3d_unit.sv */
`timescale 1ns / 1ps
// Improved 3D gradient noise, fully pipelined: one transaction per cycle in,
// one per cycle out while the output is not stalled; the result of an evaluate
// transaction is held in the output register. The permutation table is held in
// fourteen copies so that all fourteen hash lookups of one point happen in
// three pipelined memory read stages; a write transaction reaches each lookup
// level in step with the reads, so every evaluation sees the table as it stood
// when it was accepted. A write passes down the pipe as a bubble and yields no
// result. Fade curves run alongside the hash (three multiply stages), then
// gradients, then the three lerp levels, one multiply per stage, then output
// rounding and saturation to signed Q2.16. Every stage advances while the
// output register is empty or being taken, so a stall on the output side holds
// the whole pipe and drops nothing. Table entries must be written before any
// evaluation reads them.
module gradient_noise_3d_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  gn3d_in_if.sink    in_if,
  gn3d_out_if.source out_if
);
  import gn3d_pkg::*;
  `include "gradient_noise_3d_unit_macros.svh"

  localparam int unsigned Fb = FRAC_BITS;
  localparam int unsigned Tw = Fb + 2;     // fade/offset operand, signed
  localparam int unsigned Vw = Fb + 4;     // gradient sums, |v| < 4*ONE
  localparam int unsigned Fw = Fb + 5;     // fade intermediates, |v| < 16*ONE
  localparam int unsigned Stages = 7;

  pipe_ctrl_t ctrl;
  logic [Stages-1:0] vld_q;
  logic              ovld_q;

  assign ctrl.out_valid = ovld_q;
  assign ctrl.adv = !ovld_q || out_if.ready;
  assign in_if.ready = ctrl.adv;

  logic acc, we;
  assign acc = in_if.valid && in_if.ready;
  assign we  = acc && (in_if.data.action == ACT_WRITE);

  // ---------------- stage 0: split coordinates
  logic [7:0] xi, yi, zi;
  logic [Fb-1:0] xf, yf, zf;
  assign xi = 8'(in_if.data.coord_x >> Fb);
  assign yi = 8'(in_if.data.coord_y >> Fb);
  assign zi = 8'(in_if.data.coord_z >> Fb);
  assign xf = in_if.data.coord_x[Fb-1:0];
  assign yf = in_if.data.coord_y[Fb-1:0];
  assign zf = in_if.data.coord_z[Fb-1:0];

  logic [7:0] hash [8];
  gn3d_hash u_hash (
    .clk_i, .rst_ni, .adv_i(ctrl.adv), .we_i(we),
    .waddr_i(in_if.data.table_index), .wdata_i(in_if.data.table_value),
    .x_i(xi), .y_i(yi), .z_i(zi), .h_o(hash));

  // Rounded product helper: round half up then arithmetic shift by Fb.
  function automatic logic signed [2*Fw-1:0] rmul(input logic signed [Fw-1:0] a,
                                                  input logic signed [Fw-1:0] b);
    logic signed [2*Fw-1:0] p;
    p = (2*Fw)'(a) * (2*Fw)'(b);
    p = p + ((2*Fw)'(1) <<< (Fb - 1));
    return p >>> Fb;
  endfunction

  // ---------------- fade over three stages for x, y, z
  logic [Fb-1:0] f1_q [3], f2_q [3], f3_q [3];
  logic signed [Fw-1:0] sq_q [3], in_q [3], in2_q [3], cb_q [3], fd_q [3];
  logic [Fb-1:0] fr [3];
  logic signed [Fw-1:0] t0 [3], six [3];
  logic signed [Fw-1:0] one_f;
  assign fr[0] = xf;
  assign fr[1] = yf;
  assign fr[2] = zf;
  assign one_f = Fw'(1) <<< Fb;

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      t0[g]  = Fw'(fr[g]);
      six[g] = Fw'(6) * t0[g] - Fw'(15) * one_f;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      for (int g = 0; g < 3; g++) begin
        f1_q[g]  <= fr[g];
        sq_q[g]  <= Fw'(rmul(t0[g], t0[g]));
        in_q[g]  <= Fw'(rmul(t0[g], six[g])) + Fw'(10) * one_f;
        f2_q[g]  <= f1_q[g];
        in2_q[g] <= in_q[g];
        cb_q[g]  <= Fw'(rmul(sq_q[g], Fw'(f1_q[g])));
        f3_q[g]  <= f2_q[g];
        fd_q[g]  <= Fw'(rmul(cb_q[g], in2_q[g]));
      end
    end
  end
  // fd_q and hash line up after stage 3 (both three registers deep)

  // ---------------- stage 4: gradients
  logic signed [Tw-1:0] ox [2], oy [2], oz [2];
  logic signed [Tw-1:0] one_s;
  assign one_s = Tw'(1) <<< Fb;
  assign ox[0] = Tw'(f3_q[0]);
  assign oy[0] = Tw'(f3_q[1]);
  assign oz[0] = Tw'(f3_q[2]);
  assign ox[1] = ox[0] - one_s;
  assign oy[1] = oy[0] - one_s;
  assign oz[1] = oz[0] - one_s;

  function automatic logic signed [Fb+3:0] grad(input logic [3:0] h,
      input logic signed [Fb+1:0] x, input logic signed [Fb+1:0] y,
      input logic signed [Fb+1:0] z);
    logic signed [Fb+3:0] u, v;
    u = (h < 4'd8) ? (Fb+4)'(x) : (Fb+4)'(y);
    v = (h < 4'd4) ? (Fb+4)'(y) : ((h == 4'd12 || h == 4'd14) ? (Fb+4)'(x) : (Fb+4)'(z));
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic signed [Vw-1:0] g_q [8];
  logic signed [Tw-1:0] u4_q, v4_q, w4_q;
  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      for (int c = 0; c < 8; c++) begin
        g_q[c] <= grad(hash[c][3:0], ox[c[0]], oy[c[1]], oz[c[2]]);
      end
      u4_q <= Tw'(fd_q[0]);
      v4_q <= Tw'(fd_q[1]);
      w4_q <= Tw'(fd_q[2]);
    end
  end

  // ---------------- stage 5: x lerps
  logic signed [Vw-1:0] lx [4];
  for (genvar g = 0; g < 4; g++) begin : g_lx
    gn3d_blend #(.Fb(Fb), .Vw(Vw)) u_b (
      .clk_i, .adv_i(ctrl.adv), .t_i(u4_q),
      .a_i(g_q[2*g]), .b_i(g_q[2*g+1]), .r_o(lx[g]));
  end
  logic signed [Tw-1:0] v5_q, w5_q, w6_q;
  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      v5_q <= v4_q;
      w5_q <= w4_q;
      w6_q <= w5_q;
    end
  end

  // ---------------- stage 6: y lerps
  logic signed [Vw-1:0] ly [2];
  for (genvar g = 0; g < 2; g++) begin : g_ly
    gn3d_blend #(.Fb(Fb), .Vw(Vw)) u_b (
      .clk_i, .adv_i(ctrl.adv), .t_i(v5_q),
      .a_i(lx[2*g]), .b_i(lx[2*g+1]), .r_o(ly[g]));
  end

  // ---------------- stage 7: z lerp
  logic signed [Vw-1:0] lz;
  gn3d_blend #(.Fb(Fb), .Vw(Vw)) u_bz (
    .clk_i, .adv_i(ctrl.adv), .t_i(w6_q),
    .a_i(ly[0]), .b_i(ly[1]), .r_o(lz));

  // ---------------- stage 8: scale to Q2.16 and saturate
  localparam int unsigned Sw = Vw + 18;
  logic signed [Sw-1:0] sc;
  always_comb begin
    if (Fb > 16) begin
      sc = (Sw'(lz) + (Sw'(1) <<< ((Fb > 16) ? Fb - 17 : 0))) >>> ((Fb > 16) ? Fb - 16 : 0);
    end else begin
      sc = Sw'(lz) <<< ((Fb < 16) ? 16 - Fb : 0);
    end
  end
  logic signed [OutW-1:0] sat;
  always_comb begin
    if (sc > Sw'(131071)) sat = OutW'(131071);
    else if (sc < -Sw'(131072)) sat = -OutW'(131072);
    else sat = OutW'(sc);
  end

  // valid chain: evaluate transactions only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else if (ctrl.adv) begin
      vld_q  <= {vld_q[Stages-2:0], acc && (in_if.data.action == ACT_EVAL)};
      ovld_q <= vld_q[Stages-1];
    end
  end

  out_item_t out_q;
  always_ff @(posedge clk_i) begin
    if (ctrl.adv) begin
      out_q.noise_value <= sat;
    end
  end
  assign out_if.valid = ovld_q;
  assign out_if.data  = out_q;

  `GN_ASSERT(a_hold, clk_i, rst_ni, ovld_q && !out_if.ready |=> ovld_q && $stable(out_q), "output lost under stall")
  `GN_ASSERT(a_ready, clk_i, rst_ni, in_if.ready == (!ovld_q || out_if.ready), "ready mismatch")
  `GN_ASSERT(a_wr, clk_i, rst_ni, we |=> !vld_q[0], "write transaction entered datapath")
  `GN_ASSERT(a_flow, clk_i, rst_ni, ctrl.adv && vld_q[Stages-1] |=> ovld_q, "result dropped at output")
endmodule
